>>> rtl/core/asgr_pkg.sv
package asgr_pkg;

  localparam int CP_W  = 21;
  localparam int CLR_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [CP_W-1:0]  char_out;
    logic [CLR_W-1:0] fg_color;
    logic [CLR_W-1:0] bg_color;
    logic             underline_on;
    logic             section_start;
    logic             last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [CLR_W-1:0] fg;
    logic [CLR_W-1:0] bg;
    logic             ul;
  } style_t;

  typedef enum logic [2:0] {
    MODE_PLAIN = 3'b001,
    MODE_ESC   = 3'b010,
    MODE_SEQ   = 3'b100
  } mode_t;

  typedef enum logic [1:0] {
    TOK_EMPTY = 2'd0,
    TOK_NUM   = 2'd1,
    TOK_BAD   = 2'd2
  } tok_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEFAULT_FG = 3'd0,
    REG_DEFAULT_BG = 3'd1,
    REG_DEFAULT_UL = 3'd2,
    REG_PLAIN_FG   = 3'd3,
    REG_PLAIN_BG   = 3'd4
  } reg_idx_t;

  localparam logic [CP_W-1:0] CH_ESC   = 21'h1B;
  localparam logic [CP_W-1:0] CH_LBRK  = 21'h5B;
  localparam logic [CP_W-1:0] CH_M     = 21'h6D;
  localparam logic [CP_W-1:0] CH_SEMI  = 21'h3B;
  localparam logic [CP_W-1:0] CH_ZERO  = 21'h30;
  localparam logic [CP_W-1:0] CH_NINE  = 21'h39;
  localparam logic [CP_W-1:0] CH_UC_A  = 21'h41;
  localparam logic [CP_W-1:0] CH_UC_Z  = 21'h5A;
  localparam logic [CP_W-1:0] CH_LC_A  = 21'h61;
  localparam logic [CP_W-1:0] CH_LC_Z  = 21'h7A;

  localparam logic [CLR_W-1:0] SGR_RESET    = 8'd0;
  localparam logic [CLR_W-1:0] SGR_UL_ON    = 8'd4;
  localparam logic [CLR_W-1:0] SGR_UL_OFF   = 8'd24;
  localparam logic [CLR_W-1:0] SGR_FG_LO    = 8'd30;
  localparam logic [CLR_W-1:0] SGR_FG_HI    = 8'd37;
  localparam logic [CLR_W-1:0] SGR_FG_PLAIN = 8'd39;
  localparam logic [CLR_W-1:0] SGR_BG_LO    = 8'd40;
  localparam logic [CLR_W-1:0] SGR_BG_HI    = 8'd47;
  localparam logic [CLR_W-1:0] SGR_BG_PLAIN = 8'd49;
  localparam logic [CLR_W-1:0] TOK_MAX      = 8'd255;

endpackage

>>> rtl/core/ansi_sgr_style_parser_core.sv
// A result word is registered into the result queue when its input word is taken; out_data shows the queue head.
// Throughput: one input word per cycle while in_ready is high, whether it yields one
//   result or two (escape emitted as text); both results of a word enter the queue together.
// The result queue of FIFO_DEPTH entries sets the stall point: in_ready drops when
//   fewer than two entries are free.
// Reset (rst_n low, synchronous): queue empty, configuration registers zero, parser in
//   plain text.
module ansi_sgr_style_parser_core
  import asgr_pkg::*;
#(
  parameter int FIFO_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  // configuration
  style_t           dflt_r;
  logic [CLR_W-1:0] plain_fg_r, plain_bg_r;

  // parser state
  mode_t            mode_r, mode_nxt;
  style_t           cur_r, cur_nxt;
  style_t           pend_r, pend_nxt;
  logic [CLR_W-1:0] tok_val_r, tok_val_nxt;
  tok_t             tok_st_r, tok_st_nxt;
  logic             pe_r, pe_nxt;
  logic             sp_r, sp_nxt;
  logic             fresh_r, fresh_nxt;

  // result queue
  out_item_t        fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0] rd_ptr_r, wr_ptr_r;
  logic [CNT_W-1:0] count_r;

  logic             in_fire, out_fire;
  logic [1:0]       n_res;
  logic [CP_W-1:0]  e0, e1;
  style_t           cur_eff;
  out_item_t        r0, r1;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic style_t apply_tok(input tok_t st, input logic [CLR_W-1:0] v,
                                       input style_t pend, input style_t dflt,
                                       input logic [CLR_W-1:0] pfg,
                                       input logic [CLR_W-1:0] pbg);
    style_t s;
    s = pend;
    if (st == TOK_NUM) begin
      if (v == SGR_RESET) begin
        s = dflt;
      end else if (v >= SGR_FG_LO && v <= SGR_FG_HI) begin
        s.fg = v - SGR_FG_LO;
      end else if (v == SGR_FG_PLAIN) begin
        s.fg = pfg;
      end else if (v >= SGR_BG_LO && v <= SGR_BG_HI) begin
        s.bg = v - SGR_BG_LO;
      end else if (v == SGR_BG_PLAIN) begin
        s.bg = pbg;
      end else if (v == SGR_UL_ON) begin
        s.ul = 1'b1;
      end else if (v == SGR_UL_OFF) begin
        s.ul = 1'b0;
      end
    end
    return s;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (count_r <= CNT_W'(FIFO_DEPTH - 2));
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (count_r != '0);
  assign out_fire  = out_valid && out_ready;
  assign out_data  = fifo_r[rd_ptr_r];

  always_comb begin
    logic [CP_W-1:0] c;
    logic            eot, letter, digit;
    logic [11:0]     acc;
    style_t          applied;

    c       = in_data.code_point;
    eot     = in_data.end_of_text;
    letter  = (c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z);
    digit   = (c >= CH_ZERO && c <= CH_NINE);
    acc     = 12'({4'b0, tok_val_r}) * 12'd10 + 12'(c[3:0]);
    // pick up register writes made while idle before a new text
    cur_eff = fresh_r ? dflt_r : cur_r;
    applied = apply_tok(tok_st_r, tok_val_r, pend_r, dflt_r, plain_fg_r, plain_bg_r);

    mode_nxt    = mode_r;
    cur_nxt     = cur_eff;
    pend_nxt    = pend_r;
    tok_val_nxt = tok_val_r;
    tok_st_nxt  = tok_st_r;
    pe_nxt      = pe_r;
    sp_nxt      = sp_r;
    fresh_nxt   = 1'b0;
    n_res       = 2'd0;
    e0          = c;
    e1          = c;

    unique case (mode_r)
      MODE_ESC: begin
        if (c == CH_LBRK) begin
          mode_nxt    = MODE_SEQ;
          pend_nxt    = cur_eff;
          tok_val_nxt = '0;
          tok_st_nxt  = TOK_EMPTY;
          pe_nxt      = 1'b1;
        end else begin
          e0    = CH_ESC;
          n_res = 2'd1;
          if (c != CH_ESC) begin
            mode_nxt = MODE_PLAIN;
            e1       = c;
            n_res    = 2'd2;
          end
        end
      end
      MODE_SEQ: begin
        if (letter) begin
          pend_nxt = applied;
          if (c == CH_M) begin
            cur_nxt = pe_r ? dflt_r : applied;
          end
          tok_val_nxt = '0;
          tok_st_nxt  = TOK_EMPTY;
          pe_nxt      = 1'b1;
          mode_nxt    = MODE_PLAIN;
          sp_nxt      = 1'b1;
        end else begin
          pe_nxt = 1'b0;
          if (c == CH_SEMI) begin
            pend_nxt    = applied;
            tok_val_nxt = '0;
            tok_st_nxt  = TOK_EMPTY;
          end else if (digit) begin
            if (tok_st_r != TOK_BAD) begin
              tok_val_nxt = (acc > 12'(TOK_MAX)) ? TOK_MAX : acc[CLR_W-1:0];
              tok_st_nxt  = TOK_NUM;
            end
          end else begin
            tok_st_nxt = TOK_BAD;
          end
        end
      end
      default: begin
        mode_nxt = MODE_PLAIN;
        if (c == CH_ESC) begin
          mode_nxt = MODE_ESC;
        end else begin
          n_res = 2'd1;
        end
      end
    endcase

    if (n_res != 2'd0) begin
      sp_nxt = 1'b0;
    end

    if (eot) begin
      // flush a pending escape as text
      if (mode_nxt == MODE_ESC) begin
        if (n_res == 2'd0) begin
          e0 = CH_ESC;
        end else begin
          e1 = CH_ESC;
        end
        n_res = n_res + 2'd1;
      end
      mode_nxt    = MODE_PLAIN;
      tok_val_nxt = '0;
      tok_st_nxt  = TOK_EMPTY;
      pe_nxt      = 1'b1;
      sp_nxt      = 1'b1;
      fresh_nxt   = 1'b1;
      cur_nxt     = dflt_r;
    end

    r0.char_out      = e0;
    r0.fg_color      = cur_eff.fg;
    r0.bg_color      = cur_eff.bg;
    r0.underline_on  = cur_eff.ul;
    r0.section_start = sp_r;
    r0.last_of_run   = (n_res == 2'd1);
    r1.char_out      = e1;
    r1.fg_color      = cur_eff.fg;
    r1.bg_color      = cur_eff.bg;
    r1.underline_on  = cur_eff.ul;
    r1.section_start = 1'b0;
    r1.last_of_run   = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_r     <= '0;
      plain_fg_r <= '0;
      plain_bg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEFAULT_FG: dflt_r.fg  <= cfg_data;
        REG_DEFAULT_BG: dflt_r.bg  <= cfg_data;
        REG_DEFAULT_UL: dflt_r.ul  <= cfg_data[0];
        REG_PLAIN_FG:   plain_fg_r <= cfg_data;
        REG_PLAIN_BG:   plain_bg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_PLAIN;
      cur_r     <= '0;
      pend_r    <= '0;
      tok_val_r <= '0;
      tok_st_r  <= TOK_EMPTY;
      pe_r      <= 1'b1;
      sp_r      <= 1'b1;
      fresh_r   <= 1'b1;
    end else if (in_fire) begin
      mode_r    <= mode_nxt;
      cur_r     <= cur_nxt;
      pend_r    <= pend_nxt;
      tok_val_r <= tok_val_nxt;
      tok_st_r  <= tok_st_nxt;
      pe_r      <= pe_nxt;
      sp_r      <= sp_nxt;
      fresh_r   <= fresh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && n_res != 2'd0) begin
      fifo_r[wr_ptr_r] <= r0;
      if (n_res == 2'd2) begin
        fifo_r[ptr_inc(wr_ptr_r)] <= r1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (in_fire) begin
        if (n_res == 2'd1) begin
          wr_ptr_r <= ptr_inc(wr_ptr_r);
        end else if (n_res == 2'd2) begin
          wr_ptr_r <= ptr_inc(ptr_inc(wr_ptr_r));
        end
      end
      if (out_fire) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      count_r <= count_r + (in_fire ? CNT_W'(n_res) : '0) - CNT_W'(out_fire);
    end
  end

endmodule
